>>> sv/binary_to_ascii_hex_dec_assert.svh
// Assertion macros used by the binary to ASCII converter controller.
`ifndef BINARY_TO_ASCII_HEX_DEC_ASSERT_SVH
`define BINARY_TO_ASCII_HEX_DEC_ASSERT_SVH

// Check a property on every rising clock edge outside of reset.
`define BTHD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define BTHD_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> sv/bthd_pkg.sv
// Types and constants shared by the binary to ASCII converter modules.
`default_nettype none

package bthd_pkg;

    localparam int STORE_DEPTH = 20;
    localparam int IDX_W       = 5;
    localparam int IN_W        = 64;
    localparam int CHAR_W      = 7;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_X    = 7'h78;

    typedef enum logic [1:0] {
        SEL_ZERO  = 2'd0,
        SEL_X     = 2'd1,
        SEL_DIGIT = 2'd2
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      dabble;
        logic      scan;
        logic      push;
        char_sel_t sel;
        logic      last;
    } bthd_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic digit_zero;
        logic idx_zero;
        logic out_free;
    } bthd_sts_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d);
        logic [CHAR_W-1:0] res;
        if (d >= 4'hA)
            res = ASCII_A + CHAR_W'(d - 4'hA);
        else
            res = ASCII_ZERO + CHAR_W'(d);
        return res;
    endfunction

endpackage

`default_nettype wire

>>> sv/bthd_dp.sv
// Datapath: double-dabble digit register, digit pointer and output register.
`default_nettype none

module bthd_dp
    import bthd_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [IN_W-1:0]   value,
    input  wire logic              mode,
    input  wire bthd_cmd_t         cmd,
    output bthd_sts_t              sts,
    output logic [CHAR_W-1:0]      ascii_char,
    output logic                   last,
    output logic                   out_valid,
    input  wire logic              out_ready
);

    localparam int CNT_W      = $clog2(VALUE_WIDTH);
    localparam int NIBBLES    = (VALUE_WIDTH + 3) / 4;
    localparam int HEX_DIGITS = (NIBBLES > 16) ? 16 : NIBBLES;

    logic [VALUE_WIDTH-1:0]   shift_reg, shift_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [3:0]               digit_reg [STORE_DEPTH];
    logic [3:0]               digit_next [STORE_DEPTH];
    logic [3:0]               adj [STORE_DEPTH];
    logic [4*STORE_DEPTH-1:0] padded;
    logic [3:0]               cur_digit;
    logic                     out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]        char_reg, char_next;
    logic                     last_reg, last_next;

    assign padded    = (4*STORE_DEPTH)'(value[VALUE_WIDTH-1:0]);
    assign cur_digit = digit_reg[idx_reg];

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            if (digit_reg[k] >= 4'd5)
                adj[k] = digit_reg[k] + 4'd3;
            else
                adj[k] = digit_reg[k];
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        digit_next = digit_reg;
        if (cmd.load)
        begin
            shift_next = value[VALUE_WIDTH-1:0];
            cnt_next   = '0;
            if (mode)
            begin
                for (int k = 0; k < STORE_DEPTH; k++)
                    digit_next[k] = padded[4*k +: 4];
                idx_next = IDX_W'(HEX_DIGITS - 1);
            end
            else
            begin
                for (int k = 0; k < STORE_DEPTH; k++)
                    digit_next[k] = '0;
                idx_next = IDX_W'(STORE_DEPTH - 1);
            end
        end
        else if (cmd.dabble)
        begin
            for (int k = 0; k < STORE_DEPTH; k++)
            begin
                if (k == 0)
                    digit_next[k] = {adj[k][2:0], shift_reg[VALUE_WIDTH-1]};
                else
                    digit_next[k] = {adj[k][2:0], adj[k-1][3]};
            end
            shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
        end
        else if (cmd.scan || (cmd.push && cmd.sel == SEL_DIGIT && idx_reg != '0))
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
            last_next      = cmd.last;
            case (cmd.sel)
                SEL_ZERO:  char_next = ASCII_ZERO;
                SEL_X:     char_next = ASCII_X;
                SEL_DIGIT: char_next = digit_to_ascii(cur_digit);
                default:   char_next = digit_to_ascii(cur_digit);
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            shift_reg     <= shift_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign sts.conv_last  = (cnt_reg == CNT_W'(VALUE_WIDTH - 1));
    assign sts.digit_zero = (cur_digit == 4'd0);
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign ascii_char = char_reg;
    assign last       = last_reg;
    assign out_valid  = out_valid_reg;

endmodule

`default_nettype wire

>>> sv/bthd_ctrl.sv
// Controller: sequences load, conversion, zero skip and character output.
`default_nettype none
`include "binary_to_ascii_hex_dec_assert.svh"

module bthd_ctrl
    import bthd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      mode,
    output logic           in_ready,
    input  wire bthd_sts_t sts,
    output bthd_cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CONV = 6'b000010,
        ST_PFX0 = 6'b000100,
        ST_PFXX = 6'b001000,
        ST_SCAN = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mode ? ST_PFX0 : ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.dabble = 1'b1;
                if (sts.conv_last)
                    state_next = ST_SCAN;
            end
            ST_PFX0:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    cmd.sel    = SEL_ZERO;
                    state_next = ST_PFXX;
                end
            end
            ST_PFXX:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    cmd.sel    = SEL_X;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Skip leading zeros, always keep the lowest digit
                if (sts.digit_zero && !sts.idx_zero)
                    cmd.scan = 1'b1;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.push = 1'b1;
                    cmd.sel  = SEL_DIGIT;
                    cmd.last = sts.idx_zero;
                    if (sts.idx_zero)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `BTHD_ASSERT(a_push_free, clk, rst_n, !cmd.push || sts.out_free,
        "character pushed while output register is full")
    `BTHD_ASSERT_NEXT(a_load_busy, clk, rst_n, cmd.load, !in_ready,
        "input still ready after a transaction was taken")
    `BTHD_ASSERT_NEXT(a_conv_end, clk, rst_n, cmd.dabble && sts.conv_last,
        state_reg == ST_SCAN, "conversion end did not move to the zero skip")
    `BTHD_ASSERT_NEXT(a_last_idle, clk, rst_n, cmd.push && cmd.last,
        in_ready, "final character did not return to idle")

endmodule

`default_nettype wire

>>> sv/binary_to_ascii_hex_dec.sv
// Top level of the binary to ASCII decimal and hexadecimal converter.
//
// Input channel (s_*): one transaction carries a 64-bit number in s_tdata and
// the mode in s_tuser (0 decimal, 1 hex with "0x" prefix, upper case). Only
// the low VALUE_WIDTH bits of the number are used.
// Output channel (m_*): one transaction per ASCII character, most significant
// first; m_tlast marks the final character of a number.
// Timing: one number at a time, s_tready is high only while idle.
// Decimal: a load step and a serial double dabble, then the single digit read
// pointer drops leading zero digits and emits the rest (20 digits in all).
// Hex: a load step and 2 prefix characters, then the digit read pointer drops
// leading zero nibbles and emits the rest (16 nibbles for 64 bits). m_tvalid
// rises in the cycle after each character is pushed; m_tready stalls add to
// the conversion time.
// Reset: state machine returns to idle, output register empties.
// Stall: a full output register holds while m_tready is low and the
// controller waits; no character is lost or repeated.
`default_nettype none

module binary_to_ascii_hex_dec
    import bthd_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] value
    input  wire logic        s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] ascii_char, [7] zero
    output logic             m_tlast
);

    bthd_cmd_t         cmd;
    bthd_sts_t         sts;
    logic [CHAR_W-1:0] ascii_char;

    bthd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .mode     (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bthd_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (s_tdata),
        .mode       (s_tuser),
        .cmd        (cmd),
        .sts        (sts),
        .ascii_char (ascii_char),
        .last       (m_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

    assign m_tdata = {1'b0, ascii_char};

endmodule

`default_nettype wire
